// ----- sv/ffba_pkg.sv -----
// Shared types and codes of the first-fit block allocator.
// Holds the transaction payload structs, mode codes and status codes.
// No dependencies.
package ffba_pkg;

  localparam int MODE_W   = 2;
  localparam int REQ_W    = 14;
  localparam int ADDR_W   = 10;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 15;
  localparam int CFG_W    = 11;

  // Smallest legal arena length in granules.
  localparam int MIN_UNITS = 4;
  // Arena length after reset, before clamping.
  localparam int RESET_UNITS = 1024;
  // Count results saturate here.
  localparam int FREE_SAT = 32767;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_BIG   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic [FREE_W-1:0]   free_bytes;
  } out_item_t;

  typedef logic [CFG_W-1:0] cfg_word_t;

endpackage

// ----- sv/ffba_stream_if.sv -----
// Valid/ready channel used for every port of the allocator.
// The payload type is a parameter; depends on nothing else.
interface ffba_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/ffba_hdr_mem.sv -----
// Block header store: one write port and one registered read port.
// No package dependency.
module ffba_hdr_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/ffba_div.sv -----
// Division by a constant through reciprocal multiplication, quotient in the cycle after start.
// Used to round request bytes to granules; no package dependency.
module ffba_div #(
  parameter int DIVISOR = 16,
  parameter int WIDTH   = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o
);

  // The reciprocal is rounded up and scaled so that the high product bits
  // give the exact quotient for every dividend of WIDTH bits.
  localparam int     SH    = WIDTH + $clog2(DIVISOR);
  localparam int     MW    = WIDTH + 1;
  localparam int     PW    = WIDTH + MW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1))
                             / longint'(DIVISOR);

  logic [PW-1:0] prod_q, prod_d;
  logic          done_q;

  // Multiply the dividend by the scaled reciprocal.
  assign prod_d = PW'(dividend_i) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = WIDTH'(prod_q >> SH);

endmodule

// ----- sv/first_fit_block_allocator.sv -----
// First-fit block allocator over an arena of granules with lazy coalescing.
// Allocate rounds the request up to granules, then visits headers, merging a free block that is
// too small with the free blocks after it and splitting a larger fit; free walks the headers to
// the block; count walks every header and scales the free total to bytes. The result is registered.
// Throughput: one transaction at a time; a new one is taken once the result is accepted.
// Reset (async, active low) makes the arena one free block of 1024 granules, or MAX_UNITS if fewer;
// no clearing pass. Depends on ffba_pkg, ffba_stream_if, ffba_hdr_mem and ffba_div.
module first_fit_block_allocator #(
  parameter int MAX_UNITS     = 1024,
  parameter int GRANULE_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffba_stream_if.sink       cfg_i,
  ffba_stream_if.sink       in_i,
  ffba_stream_if.source     out_o
);

  import ffba_pkg::*;

  localparam int UW = $clog2(MAX_UNITS + 1);
  localparam int AW = $clog2(MAX_UNITS);
  localparam int HW = UW + 1;
  localparam int NW = REQ_W + 1;
  localparam int PW = UW + 7;
  localparam int RESET_ARENA = (RESET_UNITS > MAX_UNITS) ? MAX_UNITS : RESET_UNITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIV    = 4'd1;
  localparam logic [3:0] S_AREAD  = 4'd2;
  localparam logic [3:0] S_AHDR   = 4'd3;
  localparam logic [3:0] S_MCHK   = 4'd4;
  localparam logic [3:0] S_MHDR   = 4'd5;
  localparam logic [3:0] S_ASPLIT = 4'd6;
  localparam logic [3:0] S_FREAD  = 4'd7;
  localparam logic [3:0] S_FHDR   = 4'd8;
  localparam logic [3:0] S_CREAD  = 4'd9;
  localparam logic [3:0] S_CHDR   = 4'd10;
  localparam logic [3:0] S_CMUL   = 4'd11;
  localparam logic [3:0] S_CFIN   = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [UW-1:0]     arena_q, arena_d;
  logic              hdr0_valid_q, hdr0_valid_d;
  logic              ovr_q;
  logic [UW-1:0]     pos_q, pos_d;
  logic [UW-1:0]     acc_q, acc_d;
  logic [UW-1:0]     nxt_q, nxt_d;
  logic [NW-1:0]     need_q, need_d;
  logic [ADDR_W-1:0] faddr_q, faddr_d;
  logic [UW-1:0]     total_q, total_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic              res_valid_q, res_valid_d;
  out_item_t         res_q, res_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [HW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [HW-1:0]     mem_rdata;
  logic [HW-1:0]     hdr;
  logic [UW-1:0]     hdr_size;
  logic              hdr_alloc;

  logic              div_start;
  logic              div_done;
  logic [NW-1:0]     div_quot;
  logic [NW-1:0]     dividend;

  logic              in_fire;
  logic              cfg_fire;
  logic [UW-1:0]     cfg_units;
  logic [UW-1:0]     fit_size;
  logic              fit_go;
  logic [UW-1:0]     merge_size;
  logic              merge_end;
  logic [31:0]       grant_wide;

  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE) && !res_valid_q;
  assign cfg_i.ready = (state_q == S_IDLE);
  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  // Clamp the written arena length to the legal range.
  always_comb begin
    if (32'(cfg_i.data) < 32'(MIN_UNITS)) begin
      cfg_units = UW'(MIN_UNITS);
    end else if (32'(cfg_i.data) > 32'(MAX_UNITS)) begin
      cfg_units = UW'(MAX_UNITS);
    end else begin
      cfg_units = UW'(cfg_i.data);
    end
  end

  ffba_hdr_mem #(
    .DEPTH (MAX_UNITS),
    .WIDTH (HW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign dividend = NW'(in_i.data.request_bytes) + NW'(GRANULE_BYTES - 1);

  ffba_div #(
    .DIVISOR (GRANULE_BYTES),
    .WIDTH   (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Header 0 reads as one free block spanning the arena until it is written; a configuration write restores this.
  assign hdr       = ovr_q ? {1'b0, arena_q} : mem_rdata;
  assign hdr_alloc = hdr[UW];
  assign hdr_size  = (hdr[UW-1:0] == '0) ? UW'(1) : hdr[UW-1:0];

  assign merge_size = acc_q + hdr_size;
  assign merge_end  = (state_q == S_MCHK) ? (32'(nxt_q) >= 32'(arena_q)) : hdr_alloc;
  assign grant_wide = 32'(pos_q) + 32'd1;

  // Candidate block size for the fit test in the walk states.
  always_comb begin
    fit_size = acc_q;
    if (state_q == S_AHDR) begin
      fit_size = hdr_size;
    end
    fit_go = (32'(fit_size) >= 32'(need_q));
  end

  // Sequencer: walks headers one per read, merges and splits through one write port.
  always_comb begin
    state_d      = state_q;
    arena_d      = arena_q;
    hdr0_valid_d = hdr0_valid_q;
    pos_d        = pos_q;
    acc_d        = acc_q;
    nxt_d        = nxt_q;
    need_d       = need_q;
    faddr_d      = faddr_q;
    total_d      = total_q;
    prod_d       = prod_q;
    res_valid_d  = res_valid_q;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_waddr    = AW'(pos_q);
    mem_wdata    = '0;
    mem_raddr    = AW'(pos_q);
    div_start    = 1'b0;

    if (res_valid_q && out_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          arena_d      = cfg_units;
          hdr0_valid_d = 1'b0;
        end
        if (in_fire) begin
          pos_d   = '0;
          total_d = '0;
          faddr_d = in_i.data.block_address;
          res_d   = '0;
          case (in_i.data.mode)
            MODE_ALLOC: begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            MODE_FREE: begin
              if (in_i.data.block_address == '0) begin
                res_d.status = STATUS_NOT_ALLOC;
                res_valid_d  = 1'b1;
              end else begin
                state_d = S_FREAD;
              end
            end
            MODE_COUNT: begin
              state_d = S_CREAD;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          need_d = div_quot + NW'(1);
          if (32'(div_quot) + 32'd1 > 32'(arena_q)) begin
            res_d.status = STATUS_TOO_BIG;
            res_valid_d  = 1'b1;
            state_d      = S_IDLE;
          end else begin
            state_d = S_AREAD;
          end
        end
      end

      S_AREAD: begin
        if (32'(pos_q) >= 32'(arena_q)) begin
          res_d.status = STATUS_NO_FIT;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_AHDR;
        end
      end

      S_AHDR, S_MCHK, S_MHDR: begin
        if (state_q == S_AHDR && hdr_alloc) begin
          pos_d   = pos_q + hdr_size;
          state_d = S_AREAD;
        end else if (state_q == S_AHDR && !fit_go) begin
          acc_d   = hdr_size;
          nxt_d   = pos_q + hdr_size;
          state_d = S_MCHK;
        end else if (state_q == S_MCHK && !merge_end) begin
          mem_raddr = AW'(nxt_q);
          state_d   = S_MHDR;
        end else if (state_q == S_MHDR && !merge_end) begin
          acc_d   = merge_size;
          nxt_d   = pos_q + merge_size;
          state_d = S_MCHK;
        end else if (!fit_go) begin
          // Merged block still too small: record it and move on.
          mem_we    = 1'b1;
          mem_wdata = {1'b0, acc_q};
          if (pos_q == '0) begin
            hdr0_valid_d = 1'b1;
          end
          pos_d   = pos_q + acc_q;
          state_d = S_AREAD;
        end else if (32'(fit_size) > 32'(need_q)) begin
          // Split: remainder header first, then the granted header.
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_q + UW'(need_q));
          mem_wdata = {1'b0, fit_size - UW'(need_q)};
          state_d   = S_ASPLIT;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, fit_size};
          if (pos_q == '0) begin
            hdr0_valid_d = 1'b1;
          end
          res_d.status          = STATUS_OK;
          res_d.granted_address = grant_wide[ADDR_W-1:0];
          res_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end

      S_ASPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, UW'(need_q)};
        if (pos_q == '0) begin
          hdr0_valid_d = 1'b1;
        end
        res_d.status          = STATUS_OK;
        res_d.granted_address = grant_wide[ADDR_W-1:0];
        res_valid_d           = 1'b1;
        state_d               = S_IDLE;
      end

      S_FREAD: begin
        if (32'(pos_q) >= 32'(arena_q)) begin
          res_d.status = STATUS_NOT_ALLOC;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_FHDR;
        end
      end

      S_FHDR: begin
        if (32'(pos_q) == 32'(faddr_q) - 32'd1) begin
          if (hdr_alloc) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, hdr[UW-1:0]};
            if (pos_q == '0) begin
              hdr0_valid_d = 1'b1;
            end
            res_d.status = STATUS_OK;
          end else begin
            res_d.status = STATUS_NOT_ALLOC;
          end
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (32'(pos_q) > 32'(faddr_q)) begin
          res_d.status = STATUS_NOT_ALLOC;
          res_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end else begin
          pos_d   = pos_q + hdr_size;
          state_d = S_FREAD;
        end
      end

      S_CREAD: begin
        if (32'(pos_q) >= 32'(arena_q)) begin
          state_d = S_CMUL;
        end else begin
          state_d = S_CHDR;
        end
      end

      S_CHDR: begin
        if (!hdr_alloc) begin
          total_d = total_q + hdr_size;
        end
        pos_d   = pos_q + hdr_size;
        state_d = S_CREAD;
      end

      S_CMUL: begin
        prod_d  = PW'(total_q) * PW'(GRANULE_BYTES);
        state_d = S_CFIN;
      end

      S_CFIN: begin
        if (32'(prod_q) > 32'(FREE_SAT)) begin
          res_d.free_bytes = FREE_W'(FREE_SAT);
        end else begin
          res_d.free_bytes = FREE_W'(prod_q);
        end
        res_d.status = STATUS_OK;
        res_valid_d  = 1'b1;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      arena_q      <= UW'(RESET_ARENA);
      hdr0_valid_q <= 1'b0;
      ovr_q        <= 1'b0;
      res_valid_q  <= 1'b0;
      pos_q        <= '0;
    end else begin
      state_q      <= state_d;
      arena_q      <= arena_d;
      hdr0_valid_q <= hdr0_valid_d;
      ovr_q        <= (mem_raddr == '0) && !hdr0_valid_q;
      res_valid_q  <= res_valid_d;
      pos_q        <= pos_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    nxt_q   <= nxt_d;
    need_q  <= need_d;
    faddr_q <= faddr_d;
    total_q <= total_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
  end

  // A result is only offered while the sequencer is at rest.
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> state_q == S_IDLE)
    else $error("result offered while sequencer busy");

  // An accepted transaction always starts a walk or produces a result.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE) || res_valid_q)
    else $error("accepted transaction was dropped");

  // The walk position never passes the end of the arena.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> 32'(pos_q) <= 32'(arena_q))
    else $error("walk position beyond arena");

  // The arena length stays within its legal range.
  a_arena: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(arena_q) >= 32'(MIN_UNITS) && 32'(arena_q) <= 32'(MAX_UNITS))
    else $error("arena length out of range");

endmodule
